[design/bdil_pkg.sv]
// ----------------------------------------------------------------------------
// bdil_pkg: shared definitions for the 3x3 binary dilation block
// Sizes, register indexes and the row item and stage control structs used
// between the top level and the dilation stages.
// ----------------------------------------------------------------------------
package bdil_pkg;

	// Image and pipeline sizing
	localparam int ROW_BITS   = 64;
	localparam int MAX_PASSES = 8;
	localparam int MAX_ROWS   = 4096;
	localparam int IDX_W      = $clog2(MAX_ROWS);

	// Lane split: each lane covers LANE_BITS pixels, the row is padded up to whole lanes
	localparam int LANE_BITS  = 16;
	localparam int LANES      = (ROW_BITS + LANE_BITS - 1) / LANE_BITS;
	localparam int PAD_BITS   = LANES * LANE_BITS;

	// Configuration register fields
	localparam int WIDTH_W    = 7;
	localparam int HEIGHT_W   = 13;
	localparam int PASS_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT   = 2'd2;

	// One row travelling down the stage chain
	typedef struct packed {
		logic [ROW_BITS-1:0] bits;
		logic [IDX_W-1:0]    idx;
		logic                fin;
	} row_item_t;

	// Per-stage control from the top level
	typedef struct packed {
		logic                clr;
		logic                en;
		logic [ROW_BITS-1:0] mask;
	} stage_ctl_t;

endpackage

[design/bdil_intf.sv]
// ----------------------------------------------------------------------------
// bdil interfaces: valid/ready channels for input and output rows
// The input channel carries one image row, the output channel one dilated
// row with its index and the frame end marker.
// ----------------------------------------------------------------------------
interface bdil_in_if;
	logic                          valid;
	logic                          ready;
	logic [bdil_pkg::ROW_BITS-1:0] row_bits;

	modport source (output valid, output row_bits, input ready);
	modport sink   (input valid, input row_bits, output ready);
endinterface

interface bdil_out_if;
	logic                          valid;
	logic                          ready;
	logic [bdil_pkg::ROW_BITS-1:0] out_row_bits;
	logic [bdil_pkg::IDX_W-1:0]    out_row_index;
	logic                          frame_last;

	modport source (output valid, output out_row_bits, output out_row_index,
		output frame_last, input ready);
	modport sink   (input valid, input out_row_bits, input out_row_index,
		input frame_last, output ready);
endinterface

[design/bdil_lane.sv]
// ----------------------------------------------------------------------------
// bdil_lane: dilation of one slice of a row
// ORs the three rows of the window column-wise, then ORs each column with
// its left and right neighbor, using the edge columns of adjacent lanes.
// ----------------------------------------------------------------------------
module bdil_lane (
	input  logic [bdil_pkg::LANE_BITS-1:0] above,
	input  logic [bdil_pkg::LANE_BITS-1:0] mid,
	input  logic [bdil_pkg::LANE_BITS-1:0] below,
	input  logic                           nb_lo,
	input  logic                           nb_hi,
	input  logic [bdil_pkg::LANE_BITS-1:0] mask,
	output logic [bdil_pkg::LANE_BITS-1:0] dil
);

	logic [bdil_pkg::LANE_BITS-1:0] col;
	logic [bdil_pkg::LANE_BITS+1:0] ext;

	// vertical OR, then horizontal OR over three columns
	assign col = above | mid | below;
	assign ext = {nb_hi, col, nb_lo};
	assign dil = (ext[bdil_pkg::LANE_BITS+1:2] | ext[bdil_pkg::LANE_BITS:1]
		| ext[bdil_pkg::LANE_BITS-1:0]) & mask;

endmodule

[design/bdil_stage.sv]
// ----------------------------------------------------------------------------
// bdil_stage: one dilation pass
// Holds the two previous rows of the frame and emits the dilated middle
// row; a frame's last row also yields its final row once the output is
// free. A disabled stage forwards rows unchanged through its register.
// ----------------------------------------------------------------------------
module bdil_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bdil_pkg::stage_ctl_t  ctl,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bdil_pkg::row_item_t   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bdil_pkg::row_item_t   out_item
);

	logic [bdil_pkg::ROW_BITS-1:0] above_q;
	logic [bdil_pkg::ROW_BITS-1:0] mid_q;
	logic [bdil_pkg::IDX_W-1:0]    cnt_q;
	logic                          pend_q;
	logic                          out_valid_q;
	bdil_pkg::row_item_t           out_item_q;

	logic                          out_free;
	logic                          accept;
	logic [bdil_pkg::ROW_BITS-1:0] below;
	logic [bdil_pkg::PAD_BITS-1:0] above_p;
	logic [bdil_pkg::PAD_BITS-1:0] mid_p;
	logic [bdil_pkg::PAD_BITS-1:0] below_p;
	logic [bdil_pkg::PAD_BITS-1:0] mask_p;
	logic [bdil_pkg::PAD_BITS-1:0] col_p;
	logic [bdil_pkg::PAD_BITS-1:0] dil_p;
	logic [bdil_pkg::ROW_BITS-1:0] dil;

	// handshake: a pending final row blocks new input until it moves to the output register
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = out_free && !pend_q;
	assign accept   = in_valid && in_ready;

	// window rows; the final row of a frame sees a clear row below
	assign below   = pend_q ? '0 : in_item.bits;
	assign above_p = bdil_pkg::PAD_BITS'(above_q);
	assign mid_p   = bdil_pkg::PAD_BITS'(mid_q);
	assign below_p = bdil_pkg::PAD_BITS'(below);
	assign mask_p  = bdil_pkg::PAD_BITS'(ctl.mask);
	assign col_p   = above_p | mid_p | below_p;

	// lanes, each with the edge columns of its neighbors
	for (genvar l = 0; l < bdil_pkg::LANES; l++) begin : g_lane
		logic nb_lo;
		logic nb_hi;

		if (l == 0) begin : g_lo_edge
			assign nb_lo = 1'b0;
		end else begin : g_lo_nb
			assign nb_lo = col_p[l*bdil_pkg::LANE_BITS-1];
		end

		if (l == bdil_pkg::LANES - 1) begin : g_hi_edge
			assign nb_hi = 1'b0;
		end else begin : g_hi_nb
			assign nb_hi = col_p[(l+1)*bdil_pkg::LANE_BITS];
		end

		bdil_lane u_lane (
			.above (above_p[l*bdil_pkg::LANE_BITS +: bdil_pkg::LANE_BITS]),
			.mid   (mid_p[l*bdil_pkg::LANE_BITS +: bdil_pkg::LANE_BITS]),
			.below (below_p[l*bdil_pkg::LANE_BITS +: bdil_pkg::LANE_BITS]),
			.nb_lo (nb_lo),
			.nb_hi (nb_hi),
			.mask  (mask_p[l*bdil_pkg::LANE_BITS +: bdil_pkg::LANE_BITS]),
			.dil   (dil_p[l*bdil_pkg::LANE_BITS +: bdil_pkg::LANE_BITS])
		);
	end

	// merge lane results into one row
	assign dil = dil_p[bdil_pkg::ROW_BITS-1:0];

	// control: output valid, pending final row, row count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (ctl.clr) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
				cnt_q       <= '0;
			end else if (accept) begin
				if (ctl.en) begin
					// the first row of a frame only fills the window
					out_valid_q <= (cnt_q != '0);
					if (in_item.fin) begin
						pend_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end else begin
					out_valid_q <= 1'b1;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: window shift and output row
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_item_q.bits <= dil;
				out_item_q.idx  <= cnt_q;
				out_item_q.fin  <= 1'b1;
			end else if (accept) begin
				if (ctl.en) begin
					out_item_q.bits <= dil;
					out_item_q.idx  <= cnt_q - 1'b1;
					out_item_q.fin  <= 1'b0;
					above_q         <= (cnt_q != '0) ? mid_q : '0;
					mid_q           <= in_item.bits;
				end else begin
					out_item_q <= in_item;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[design/binary_dilation_3x3.sv]
// ----------------------------------------------------------------------------
// binary_dilation_3x3: repeated 3x3 binary dilation of a streamed bit image
// Registers: one output register per stage; each enabled pass adds one
//   row of delay on top.
// Throughput: one row per cycle unless the output stalls; a frame's last row
//   blocks input at each enabled stage while that stage emits its final row.
// Reset: width 64, height 64, one pass; all row counts clear. Any write to
//   a known register restarts the frame.
// ----------------------------------------------------------------------------
module binary_dilation_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bdil_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bdil_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	bdil_in_if.sink                          row_in,
	bdil_out_if.source                       row_out
);

	logic [bdil_pkg::ROW_BITS-1:0]   mask_q;
	logic [bdil_pkg::IDX_W-1:0]      last_row_q;
	logic [bdil_pkg::PASS_W-1:0]     passes_q;
	logic [bdil_pkg::IDX_W-1:0]      row_cnt_q;

	logic                            clr;
	logic [bdil_pkg::ROW_BITS-1:0]   mask_n;
	logic [bdil_pkg::IDX_W-1:0]      last_row_n;
	logic [bdil_pkg::HEIGHT_W-1:0]   height;
	logic                            in_fin;
	logic                            in_accept;

	logic [bdil_pkg::MAX_PASSES:0]   chain_valid;
	logic [bdil_pkg::MAX_PASSES:0]   chain_ready;
	bdil_pkg::row_item_t             chain_item [bdil_pkg::MAX_PASSES+1];
	bdil_pkg::stage_ctl_t            stage_ctl  [bdil_pkg::MAX_PASSES];

	// a write to a known register restarts the frame
	always_comb begin
		unique case (cfg_index)
			bdil_pkg::REG_IMAGE_WIDTH,
			bdil_pkg::REG_IMAGE_HEIGHT,
			bdil_pkg::REG_PASS_COUNT: clr = cfg_we;
			default:                  clr = 1'b0;
		endcase
	end

	// row mask from the width; widths past the row size keep every bit
	always_comb begin
		for (int i = 0; i < bdil_pkg::ROW_BITS; i++) begin
			mask_n[i] = (32'(cfg_wdata[bdil_pkg::WIDTH_W-1:0]) > i);
		end
	end

	// last row index from the clamped height
	assign height = cfg_wdata[bdil_pkg::HEIGHT_W-1:0];

	always_comb begin
		priority if (height == '0) begin
			last_row_n = '0;
		end else if (32'(height) > bdil_pkg::MAX_ROWS) begin
			last_row_n = bdil_pkg::IDX_W'(bdil_pkg::MAX_ROWS - 1);
		end else begin
			last_row_n = bdil_pkg::IDX_W'(height - 1'b1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '1;
			last_row_q <= bdil_pkg::IDX_W'(63);
			passes_q   <= bdil_pkg::PASS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdil_pkg::REG_IMAGE_WIDTH:  mask_q     <= mask_n;
				bdil_pkg::REG_IMAGE_HEIGHT: last_row_q <= last_row_n;
				bdil_pkg::REG_PASS_COUNT:   passes_q   <= cfg_wdata[bdil_pkg::PASS_W-1:0];
				default: ;
			endcase
		end
	end

	// input row counter
	assign in_accept = row_in.valid && row_in.ready;
	assign in_fin    = (row_cnt_q >= last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (clr) begin
			row_cnt_q <= '0;
		end else if (in_accept) begin
			row_cnt_q <= in_fin ? '0 : row_cnt_q + 1'b1;
		end
	end

	// head of the stage chain
	assign chain_valid[0]     = row_in.valid;
	assign row_in.ready       = chain_ready[0];
	assign chain_item[0].bits = row_in.row_bits & mask_q;
	assign chain_item[0].idx  = row_cnt_q;
	assign chain_item[0].fin  = in_fin;

	// one stage per pass; stages past the pass count forward rows
	for (genvar k = 0; k < bdil_pkg::MAX_PASSES; k++) begin : g_stage
		assign stage_ctl[k].clr  = clr;
		assign stage_ctl[k].en   = (32'(passes_q) > k);
		assign stage_ctl[k].mask = mask_q;

		bdil_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (stage_ctl[k]),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	// tail of the chain drives the output channel
	assign row_out.valid                     = chain_valid[bdil_pkg::MAX_PASSES];
	assign chain_ready[bdil_pkg::MAX_PASSES] = row_out.ready;
	assign row_out.out_row_bits              = chain_item[bdil_pkg::MAX_PASSES].bits;
	assign row_out.out_row_index             = chain_item[bdil_pkg::MAX_PASSES].idx;
	assign row_out.frame_last                = chain_item[bdil_pkg::MAX_PASSES].fin;

endmodule

[design/bdil_checker.sv]
// ----------------------------------------------------------------------------
// bdil_checker: port-level checks for binary_dilation_3x3
// Tracks the expected output row index and the configured frame height
// and checks row order, the frame end marker and output stalls.
// ----------------------------------------------------------------------------
module bdil_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [bdil_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [bdil_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [bdil_pkg::ROW_BITS-1:0]    out_row_bits,
	input logic [bdil_pkg::IDX_W-1:0]       out_row_index,
	input logic                             frame_last
);

	logic [bdil_pkg::IDX_W-1:0]    exp_idx_q;
	logic [bdil_pkg::IDX_W-1:0]    last_q;
	logic [bdil_pkg::HEIGHT_W-1:0] height;
	logic                          out_accept;
	logic                          restart;

	assign out_accept = out_valid && out_ready;
	assign height     = cfg_wdata[bdil_pkg::HEIGHT_W-1:0];
	assign restart    = cfg_we && (cfg_index == bdil_pkg::REG_IMAGE_WIDTH
		|| cfg_index == bdil_pkg::REG_IMAGE_HEIGHT || cfg_index == bdil_pkg::REG_PASS_COUNT);

	// expected index of the next output row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (restart) begin
			exp_idx_q <= '0;
		end else if (out_accept) begin
			exp_idx_q <= frame_last ? '0 : out_row_index + 1'b1;
		end
	end

	// last row index of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= bdil_pkg::IDX_W'(63);
		end else if (cfg_we && cfg_index == bdil_pkg::REG_IMAGE_HEIGHT) begin
			priority if (height == '0) begin
				last_q <= '0;
			end else if (32'(height) > bdil_pkg::MAX_ROWS) begin
				last_q <= bdil_pkg::IDX_W'(bdil_pkg::MAX_ROWS - 1);
			end else begin
				last_q <= bdil_pkg::IDX_W'(height - 1'b1);
			end
		end
	end

	// output rows come in frame order
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> out_row_index == exp_idx_q)
		else $error("output row index out of order");

	// frame end marker sits exactly on the last row of the frame
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> frame_last == (out_row_index == last_q))
		else $error("frame_last does not match the last row");

	// a stalled output row holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row_bits)
			&& $stable(out_row_index) && $stable(frame_last))
		else $error("output row changed while stalled");

endmodule

bind binary_dilation_3x3 bdil_checker u_bdil_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_wdata     (cfg_wdata),
	.out_valid     (row_out.valid),
	.out_ready     (row_out.ready),
	.out_row_bits  (row_out.out_row_bits),
	.out_row_index (row_out.out_row_index),
	.frame_last    (row_out.frame_last)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binary_dilation_3x3
// Streams image rows through the block under changing width, height and
// pass settings, predicts every dilated row with a cycle-free model of the
// stage chain, and checks each output row in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ROWS    = 50;

	// Index with no register behind it
	localparam logic [bdil_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	// Predicts the dilated rows of the stage chain and holds those still due
	class dilation_scoreboard;
		logic [bdil_pkg::ROW_BITS-1:0] stage_above[bdil_pkg::MAX_PASSES];
		logic [bdil_pkg::ROW_BITS-1:0] stage_mid[bdil_pkg::MAX_PASSES];
		int unsigned                   stage_rows_seen[bdil_pkg::MAX_PASSES];
		int unsigned                   frame_row_num;
		int unsigned                   width_cfg;
		int unsigned                   height_cfg;
		int unsigned                   passes_cfg;
		bdil_pkg::row_item_t           dilated_rows_due[$];
		int unsigned                   mismatches;

		function new();
			width_cfg  = 64;
			height_cfg = 64;
			passes_cfg = 1;
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			for (int k = 0; k < bdil_pkg::MAX_PASSES; k++) begin
				stage_above[k]     = '0;
				stage_mid[k]       = '0;
				stage_rows_seen[k] = 0;
			end
			frame_row_num = 0;
		endfunction

		// Unmapped indexes leave the frame running
		function void write_register(logic [bdil_pkg::CFG_IDX_W-1:0] index,
			int unsigned value);
			case (index)
				bdil_pkg::REG_IMAGE_WIDTH: begin
					width_cfg = value & 32'h7f;
				end
				bdil_pkg::REG_IMAGE_HEIGHT: begin
					height_cfg = value & 32'h1fff;
				end
				bdil_pkg::REG_PASS_COUNT: begin
					passes_cfg = value & 32'hf;
				end
				default: begin
					return;
				end
			endcase
			clear_frame();
		endfunction

		// One 3x3 step: OR of three rows, spread one pixel left and right
		function logic [bdil_pkg::ROW_BITS-1:0] grow3(logic [bdil_pkg::ROW_BITS-1:0] above,
			logic [bdil_pkg::ROW_BITS-1:0] mid, logic [bdil_pkg::ROW_BITS-1:0] below,
			logic [bdil_pkg::ROW_BITS-1:0] mask);
			logic [bdil_pkg::ROW_BITS-1:0] m;
			m = above | mid | below;
			return (m | (m << 1) | (m >> 1)) & mask;
		endfunction

		// Runs one accepted input row down the chain, queues the rows it releases
		function void take_input_row(logic [bdil_pkg::ROW_BITS-1:0] bits);
			bdil_pkg::row_item_t           cur[$];
			bdil_pkg::row_item_t           nxt[$];
			bdil_pkg::row_item_t           r;
			bdil_pkg::row_item_t           o;
			logic [bdil_pkg::ROW_BITS-1:0] mask;
			logic [bdil_pkg::ROW_BITS-1:0] a;
			logic [bdil_pkg::ROW_BITS-1:0] b;
			logic [bdil_pkg::ROW_BITS-1:0] v;
			int unsigned                   w;
			int unsigned                   h;
			int unsigned                   p;
			int unsigned                   c;

			w = (width_cfg > bdil_pkg::ROW_BITS) ? bdil_pkg::ROW_BITS : width_cfg;
			mask = (w >= 64) ? {bdil_pkg::ROW_BITS{1'b1}} : ((64'd1 << w) - 64'd1);
			h = (height_cfg < 1) ? 1 : height_cfg;
			if (h > bdil_pkg::MAX_ROWS) h = bdil_pkg::MAX_ROWS;
			p = (passes_cfg > bdil_pkg::MAX_PASSES) ? bdil_pkg::MAX_PASSES : passes_cfg;

			r.bits = bits & mask;
			r.idx  = bdil_pkg::IDX_W'(frame_row_num);
			r.fin  = (frame_row_num + 1 >= h);
			frame_row_num = r.fin ? 0 : frame_row_num + 1;
			cur = {cur, r};

			for (int k = 0; k < p; k++) begin
				nxt.delete();
				foreach (cur[i]) begin
					c = stage_rows_seen[k];
					a = stage_above[k];
					b = stage_mid[k];
					v = cur[i].bits;
					// a stage emits the row above once it has seen one
					if (c != 0) begin
						o.bits = grow3(a, b, v, mask);
						o.idx  = bdil_pkg::IDX_W'(c - 1);
						o.fin  = 1'b0;
						nxt = {nxt, o};
					end
					stage_above[k] = (c != 0) ? b : '0;
					stage_mid[k]   = v;
					// frame end: flush the held row against a clear row below
					if (cur[i].fin) begin
						o.bits = grow3(stage_above[k], v, '0, mask);
						o.idx  = bdil_pkg::IDX_W'(c);
						o.fin  = 1'b1;
						nxt = {nxt, o};
						stage_rows_seen[k] = 0;
						stage_above[k]     = '0;
						stage_mid[k]       = '0;
					end else begin
						stage_rows_seen[k] = c + 1;
					end
				end
				cur = nxt;
			end

			dilated_rows_due = {dilated_rows_due, cur};
		endfunction

		function void check_output_row(bdil_pkg::row_item_t got);
			bdil_pkg::row_item_t want;
			if (dilated_rows_due.size() == 0) begin
				$error("unexpected output row: bits %h index %0d last %0b",
					got.bits, got.idx, got.fin);
				mismatches++;
				return;
			end
			want = dilated_rows_due.pop_front();
			if (got.bits !== want.bits) begin
				$error("out_row_bits: expected %h, actual %h", want.bits, got.bits);
				mismatches++;
			end
			if (got.idx !== want.idx) begin
				$error("out_row_index: expected %0d, actual %0d", want.idx, got.idx);
				mismatches++;
			end
			if (got.fin !== want.fin) begin
				$error("frame_last: expected %0b, actual %0b", want.fin, got.fin);
				mismatches++;
			end
		endfunction

		function int unsigned rows_due();
			return dilated_rows_due.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bdil_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bdil_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bdil_in_if  row_in_ch ();
	bdil_out_if row_out_ch ();

	dilation_scoreboard sb;
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	int unsigned        cycle_count;

	binary_dilation_3x3 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.row_in    (row_in_ch),
		.row_out   (row_out_ch)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Output side: random stalls, ready set at the falling edge
	always @(negedge clk) begin
		row_out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Output monitor
	always @(posedge clk) begin
		bdil_pkg::row_item_t got;
		if (arst_n && row_out_ch.valid && row_out_ch.ready) begin
			got.bits = row_out_ch.out_row_bits;
			got.idx  = row_out_ch.out_row_index;
			got.fin  = row_out_ch.frame_last;
			sb.check_output_row(got);
		end
	end

	// Offers one row after random idle cycles, notes it once accepted
	task automatic send_row(logic [bdil_pkg::ROW_BITS-1:0] bits);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			row_in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_in_ch.valid    <= 1'b1;
		row_in_ch.row_bits <= bits;
		do @(posedge clk); while (!row_in_ch.ready);
		sb.take_input_row(bits);
	endtask

	// Holds the input off until every predicted row has come out
	task automatic wait_rows_out();
		@(negedge clk);
		row_in_ch.valid <= 1'b0;
		while (sb.rows_due() != 0) @(posedge clk);
	endtask

	// Register write on an idle block; rows still held in stages must settle first
	task automatic write_reg(logic [bdil_pkg::CFG_IDX_W-1:0] index, int unsigned value);
		wait_rows_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value[bdil_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.write_register(index, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [bdil_pkg::ROW_BITS-1:0] random_row();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random settings, mostly whole frames, some cut short by the next write
	task automatic random_frames(int unsigned n_items);
		int unsigned sent;
		int unsigned rows;
		int unsigned h_eff;
		bit          paused;
		sent   = 0;
		paused = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0: write_reg(bdil_pkg::REG_IMAGE_WIDTH, 0);
					1: write_reg(bdil_pkg::REG_IMAGE_WIDTH, $urandom_range(65, 127));
					2: write_reg(bdil_pkg::REG_IMAGE_WIDTH, 1);
					3: write_reg(bdil_pkg::REG_IMAGE_WIDTH, 64);
					default: write_reg(bdil_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 64));
				endcase
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0: write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 0);
					1: write_reg(bdil_pkg::REG_IMAGE_HEIGHT, $urandom_range(4097, 8191));
					default: write_reg(bdil_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 12));
				endcase
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0: write_reg(bdil_pkg::REG_PASS_COUNT, $urandom_range(9, 15));
					1: write_reg(bdil_pkg::REG_PASS_COUNT, 0);
					2: write_reg(bdil_pkg::REG_PASS_COUNT, 8);
					3: write_reg(REG_UNMAPPED, $urandom_range(0, 8191));
					default: write_reg(bdil_pkg::REG_PASS_COUNT, $urandom_range(1, 8));
				endcase
			end
			h_eff = (sb.height_cfg < 1) ? 1 : sb.height_cfg;
			if (h_eff > 12)
				rows = $urandom_range(1, 20);
			else if ($urandom_range(0, 4) == 0)
				rows = $urandom_range(1, h_eff);
			else
				rows = h_eff * $urandom_range(1, 2);
			repeat (rows) begin
				send_row(random_row());
				sent++;
			end
			// one hold-off per phase until the output has caught up
			if (!paused && sent >= n_items / 2) begin
				wait_rows_out();
				paused = 1;
			end
		end
	endtask

	initial begin
		int unsigned send_pcts[3];
		int unsigned recv_pcts[3];

		send_pcts = '{19, 59, 0};
		recv_pcts = '{59, 19, 0};
		sb = new();
		cycle_count        = 0;
		send_idle_pct      = send_pcts[0];
		recv_idle_pct      = recv_pcts[0];
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		row_in_ch.valid    = 1'b0;
		row_in_ch.row_bits = '0;
		row_out_ch.ready   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Full width, one pass, three-row frame: extremes of the row
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 3);
		send_row('1);
		send_row('0);
		send_row(64'h8000_0000_0000_0000);

		// Zero passes: masked pass-through
		write_reg(bdil_pkg::REG_PASS_COUNT, 0);
		write_reg(bdil_pkg::REG_IMAGE_WIDTH, 5);
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 2);
		send_row('1);
		send_row(64'h8000_0000_0000_0001);

		// Width zero clears every row
		write_reg(bdil_pkg::REG_IMAGE_WIDTH, 0);
		write_reg(bdil_pkg::REG_PASS_COUNT, 2);
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 4);
		repeat (4) send_row(random_row());

		// Width, pass count over range; height zero means one-row frames
		write_reg(bdil_pkg::REG_IMAGE_WIDTH, 100);
		write_reg(bdil_pkg::REG_PASS_COUNT, 15);
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 0);
		repeat (2) send_row({$urandom, $urandom});

		// Height over range, single-pixel width
		write_reg(bdil_pkg::REG_PASS_COUNT, 0);
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 8191);
		write_reg(bdil_pkg::REG_IMAGE_WIDTH, 1);
		send_row('1);
		send_row({$urandom, $urandom});

		// All passes, frame end flushes the whole chain;
		// an unmapped write in mid-frame must not restart it
		write_reg(bdil_pkg::REG_IMAGE_WIDTH, 64);
		write_reg(bdil_pkg::REG_PASS_COUNT, 8);
		write_reg(bdil_pkg::REG_IMAGE_HEIGHT, 10);
		repeat (5) send_row(random_row());
		write_reg(REG_UNMAPPED, 8191);
		repeat (5) send_row(random_row());

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_idle_pct = recv_pcts[ph];
			random_frames(PHASE_ROWS);
		end

		wait_rows_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
